FILE: src/hvn_pkg.sv
package hvn_pkg;

    localparam int DEF_MAX_SIDE = 128;
    localparam int CFG_IDX_W    = 2;
    localparam int ACC_W        = 12;
    localparam int SUMSQ_W      = 23;
    localparam int NRM_W        = 16;
    localparam int NB_COUNT     = 7;

    localparam logic [7:0] SIDE_RESET = 8'd128;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLUMNS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS    = 2'd1;

    typedef struct packed {
        logic       func;
        logic [6:0] column;
        logic [6:0] row;
        logic [7:0] sample;
    } t_in_word;

    typedef struct packed {
        logic [7:0]        height_raw;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic              out_of_range;
    } t_out_word;

    typedef struct packed {
        logic done;
        logic busy;
    } t_norm_stat;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SUM,
        ST_SQ,
        ST_NSTART,
        ST_NWAIT,
        ST_DONE
    } t_state;

endpackage

FILE: src/hvn_norm.sv
module hvn_norm (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [hvn_pkg::ACC_W-1:0]   i_comp,
    input  logic [hvn_pkg::SUMSQ_W-1:0]        i_sumsq,
    output logic signed [hvn_pkg::NRM_W-1:0]   o_result,
    output hvn_pkg::t_norm_stat                o_stat
);
    import hvn_pkg::*;

    localparam int W = 55;

    logic [W-1:0]       r_n, r_p, r_d, r_a;
    logic [W-1:0]       n_trial;
    logic [15:0]        r_t;
    logic [3:0]         r_b;
    logic               r_busy, r_done, r_neg;
    logic [ACC_W-2:0]   n_mag;
    logic [2*ACC_W-3:0] n_sq;
    logic               n_take;
    logic [16:0]        n_m;

    always_comb begin
        n_mag   = i_comp[ACC_W-1] ? (ACC_W-1)'(-i_comp) : i_comp[ACC_W-2:0];
        n_sq    = {{(ACC_W-1){1'b0}}, n_mag} * {{(ACC_W-1){1'b0}}, n_mag};
        n_trial = r_p + r_d + r_a;
        n_take  = (n_trial <= r_n);
        n_m     = ({1'b0, r_t} + 17'd1) >> 1;
        o_result = r_neg ? -NRM_W'(n_m) : NRM_W'(n_m);
        o_stat.done = r_done;
        o_stat.busy = r_busy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_b == 4'd0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n   <= W'(n_sq) << 30;
            r_p   <= '0;
            r_d   <= '0;
            r_a   <= W'(i_sumsq) << 30;
            r_t   <= '0;
            r_b   <= 4'd15;
            r_neg <= i_comp[ACC_W-1];
        end else if (r_busy) begin
            if (n_take) begin
                r_p <= n_trial;
                r_d <= (r_d >> 1) + r_a;
            end else begin
                r_d <= r_d >> 1;
            end
            r_a <= r_a >> 2;
            r_t <= {r_t[14:0], n_take};
            r_b <= r_b - 4'd1;
        end
    end

endmodule

FILE: src/heightmap_vertex_normal.sv
// Height-map vertex normal unit.
// Input channel (i_in_valid / o_in_stall, word i_in_data): func 0 stores one
// height byte at pixel (column, row), row flipped against grid_rows; func 1
// queries vertex (column, row) and yields one output word.
// Output channel (o_out_valid / i_out_stall, word o_out_data): height byte,
// unit normal in signed Q1.14 rounded to nearest, out_of_range flag.
// Config channel (i_cfg_valid / o_cfg_ready): index 0 grid_columns,
// index 1 grid_rows, clamped to 2..MAX_SIDE. Ready is always high.
// A load writes one height byte directly into the height memory. A query reads
// seven neighbor heights from the height memory, sums the triangle normals,
// forms the squared length from the three components, then runs a shared
// 16-step restoring square-root/divide unit once per component. An
// out-of-range query skips the reads and goes straight to the output register.
// The result waits in an output register; a stalled receiver holds it, and
// the block stalls its input only while a query is in flight.
// Reset sets both grid sizes to 128 and empties the output register; the
// height memory is not cleared and holds garbage until written.
module heightmap_vertex_normal #(
    parameter int MAX_SIDE = hvn_pkg::DEF_MAX_SIDE
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  hvn_pkg::t_in_word                 i_in_data,
    output logic                              o_in_stall,
    output logic                              o_out_valid,
    output hvn_pkg::t_out_word                o_out_data,
    input  logic                              i_out_stall,
    input  logic                              i_cfg_valid,
    input  logic [hvn_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [7:0]                        i_cfg_data,
    output logic                              o_cfg_ready
);
    import hvn_pkg::*;

    localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
    localparam int ADDR_W = $clog2(DEPTH);

    localparam logic [7:0] NB_DX [NB_COUNT] = '{8'd0, 8'd1, 8'd0, 8'hFF, 8'hFF, 8'd0, 8'd1};
    localparam logic [7:0] NB_DZ [NB_COUNT] = '{8'd0, 8'd0, 8'd1, 8'd0, 8'd1, 8'hFF, 8'hFF};

    function automatic logic [7:0] clamp_side(input logic [7:0] v);
        logic [7:0] r;
        r = v;
        if (v < 8'd2) r = 8'd2;
        else if (int'(v) > MAX_SIDE) r = 8'(MAX_SIDE);
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [7:0] x, input logic [7:0] z);
        return ADDR_W'(int'(z) * MAX_SIDE + int'(x));
    endfunction

    logic [7:0]   r_mem [DEPTH];
    logic [7:0]   r_rd;
    logic [7:0]   r_cols, r_rows;
    t_state       r_state, n_state;
    logic [6:0]   r_col, r_row;
    logic         r_oor;
    logic [2:0]   r_k;
    logic [1:0]   r_i;
    logic [7:0]   r_h [NB_COUNT];
    logic signed [ACC_W-1:0] r_acc [3];
    logic signed [NRM_W-1:0] r_nrm [3];
    logic [SUMSQ_W-1:0] r_s;
    logic         r_ov;
    t_out_word    r_out;

    logic         in_acc, out_free, vx_lo, vx_hi, vz_lo, vz_hi;
    logic         n_wr, n_start;
    logic [ADDR_W-1:0] n_waddr, n_raddr;
    logic [7:0]   n_vrow;
    logic signed [ACC_W-1:0] n_acc [3];
    logic signed [ACC_W-1:0] hc, he, hn, hw, hnw, hs, hse, sel_c;
    logic [ACC_W-2:0] sel_mag;
    logic [2*ACC_W-3:0] sel_sq;
    logic signed [NRM_W-1:0] norm_res;
    t_norm_stat   norm_stat;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_free    = !r_ov || !i_out_stall;
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= SIDE_RESET;
            r_rows <= SIDE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_GRID_COLUMNS: r_cols <= clamp_side(i_cfg_data);
                CFG_GRID_ROWS:    r_rows <= clamp_side(i_cfg_data);
                default: ;
            endcase
        end
    end

    always_comb begin
        n_vrow  = r_rows - 8'd1 - {1'b0, i_in_data.row};
        n_waddr = cell_addr({1'b0, i_in_data.column}, n_vrow);
        n_wr    = in_acc && i_in_data.func == FUNC_LOAD
                  && {1'b0, i_in_data.column} < r_cols && {1'b0, i_in_data.row} < r_rows;
        n_raddr = cell_addr({1'b0, r_col} + NB_DX[r_k], {1'b0, r_row} + NB_DZ[r_k]);
    end

    always_ff @(posedge i_clk) begin
        if (n_wr) r_mem[n_waddr] <= i_in_data.sample;
        r_rd <= r_mem[n_raddr];
    end

    always_comb begin
        vx_lo = (r_col != 7'd0);
        vz_lo = (r_row != 7'd0);
        vx_hi = ({1'b0, r_col} + 8'd1) < r_cols;
        vz_hi = ({1'b0, r_row} + 8'd1) < r_rows;
        hc  = $signed({4'd0, r_h[0]});
        he  = $signed({4'd0, r_h[1]});
        hn  = $signed({4'd0, r_h[2]});
        hw  = $signed({4'd0, r_h[3]});
        hnw = $signed({4'd0, r_h[4]});
        hs  = $signed({4'd0, r_h[5]});
        hse = $signed({4'd0, r_h[6]});
        n_acc[0] = '0;
        n_acc[1] = '0;
        n_acc[2] = '0;
        if (vx_hi && vz_hi) begin
            n_acc[0] = n_acc[0] + hc - he;
            n_acc[1] = n_acc[1] + 12'sd10;
            n_acc[2] = n_acc[2] + hc - hn;
        end
        if (vx_lo && vz_hi) begin
            n_acc[0] = n_acc[0] + hw - hc + hnw - hn;
            n_acc[1] = n_acc[1] + 12'sd20;
            n_acc[2] = n_acc[2] + hw - hnw + hc - hn;
        end
        if (vx_hi && vz_lo) begin
            n_acc[0] = n_acc[0] + hs - hse + hc - he;
            n_acc[1] = n_acc[1] + 12'sd20;
            n_acc[2] = n_acc[2] + hs - hc + hse - he;
        end
        if (vx_lo && vz_lo) begin
            n_acc[0] = n_acc[0] + hw - hc;
            n_acc[1] = n_acc[1] + 12'sd10;
            n_acc[2] = n_acc[2] + hs - hc;
        end
        sel_c   = r_acc[r_i];
        sel_mag = sel_c[ACC_W-1] ? (ACC_W-1)'(-sel_c) : sel_c[ACC_W-2:0];
        sel_sq  = {{(ACC_W-1){1'b0}}, sel_mag} * {{(ACC_W-1){1'b0}}, sel_mag};
    end

    always_comb begin
        n_state = r_state;
        n_start = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && i_in_data.func == FUNC_QUERY) begin
                    if ({1'b0, i_in_data.column} < r_cols && {1'b0, i_in_data.row} < r_rows)
                        n_state = ST_READ;
                    else
                        n_state = ST_DONE;
                end
            end
            ST_READ:   if (r_k == 3'd7) n_state = ST_SUM;
            ST_SUM:    n_state = ST_SQ;
            ST_SQ:     if (r_i == 2'd2) n_state = ST_NSTART;
            ST_NSTART: begin
                n_start = 1'b1;
                n_state = ST_NWAIT;
            end
            ST_NWAIT: begin
                if (norm_stat.done) n_state = (r_i == 2'd2) ? ST_DONE : ST_NSTART;
            end
            ST_DONE:   if (out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_DONE && out_free) r_ov <= 1'b1;
            else if (!i_out_stall) r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_col <= i_in_data.column;
                r_row <= i_in_data.row;
                r_oor <= !({1'b0, i_in_data.column} < r_cols && {1'b0, i_in_data.row} < r_rows);
                r_k   <= 3'd0;
            end
            ST_READ: begin
                if (r_k != 3'd0) r_h[r_k - 3'd1] <= r_rd;
                r_k <= r_k + 3'd1;
            end
            ST_SUM: begin
                r_acc[0] <= n_acc[0];
                r_acc[1] <= n_acc[1];
                r_acc[2] <= n_acc[2];
                r_s <= '0;
                r_i <= 2'd0;
            end
            ST_SQ: begin
                r_s <= r_s + SUMSQ_W'(sel_sq);
                r_i <= (r_i == 2'd2) ? 2'd0 : r_i + 2'd1;
            end
            ST_NSTART: ;
            ST_NWAIT: begin
                if (norm_stat.done) begin
                    r_nrm[r_i] <= norm_res;
                    r_i <= r_i + 2'd1;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    r_out.out_of_range <= r_oor;
                    r_out.height_raw   <= r_oor ? 8'd0 : r_h[0];
                    r_out.normal_x     <= r_oor ? '0 : r_nrm[0];
                    r_out.normal_y     <= r_oor ? '0 : r_nrm[1];
                    r_out.normal_z     <= r_oor ? '0 : r_nrm[2];
                end
            end
            default: ;
        endcase
    end

    hvn_norm u_norm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (n_start),
        .i_comp   (sel_c),
        .i_sumsq  (r_s),
        .o_result (norm_res),
        .o_stat   (norm_stat)
    );

endmodule
